### src/mtg_pkg.sv
// ============================================================================
// mtg_pkg: shared types, constants and functions of the MT19937 generator
// Holds the twist and tempering functions and the state memory write request.
// ============================================================================
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int WORD_W       = 32;

    localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] WRAP_BASE = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_STEP  = ADDR_W'(SHIFT_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_BACK  = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);

    // request codes
    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_RESEED = 1'b1;

    // one write request into the state memory
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mtg_wr_t;

    // new word from the current, next and far words
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] mix;
        y   = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
        mix = (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
        return far ^ mix;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] n;
        n = w;
        n = n ^ (n >> 11);
        n = n ^ ((n << 7) & TEMPER_B);
        n = n ^ ((n << 15) & TEMPER_C);
        n = n ^ (n >> 18);
        return n;
    endfunction

endpackage

### src/mtg_state_ram.sv
// ============================================================================
// mtg_state_ram: state word memory
// One write port and two registered read ports.
// ============================================================================
module mtg_state_ram
    import mtg_pkg::*;
(
    input  logic              clk,
    input  mtg_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [STATE_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/mtg_seed_fill.sv
// ============================================================================
// mtg_seed_fill: seed expansion sequencer
// Writes one state word per cycle from the seed by the multiply-xor recurrence.
// ============================================================================
module mtg_seed_fill
    import mtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] seed,
    output mtg_wr_t           wr,
    output logic              busy
);

    logic              busy_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] word;

    assign mixed   = prev_reg ^ (prev_reg >> 30);
    assign product = mixed * SEED_MULT;
    // word zero is the seed itself
    assign word    = (idx_reg == '0) ? prev_reg : product + WORD_W'(idx_reg);

    assign wr.en   = busy_reg;
    assign wr.addr = idx_reg;
    assign wr.data = word;
    assign busy    = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (idx_reg == LAST_ADDR)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prev_reg <= seed;
        end
        else if (busy_reg)
        begin
            prev_reg <= word;
        end
    end

endmodule

### src/mersenne_twister_generator.sv
// ============================================================================
// mersenne_twister_generator: MT19937 32-bit pseudo-random generator
// Draws tempered words from a 624-word state memory twisted one word per draw.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one request: action selects a
//   draw or a reseed from seed_value. Output channel (out_valid / out_stall)
//   carries one random_word per draw; a reseed returns nothing.
//   Draw: the request is taken in idle, the two state words it needs are read
//   at that edge, and the twisted and tempered word lands in the output
//   register when the compute state finishes, once that register is free.
//   No new request is taken until the compute state has returned to idle.
//   Reseed: the seed expansion writes one word per cycle through a single
//   multiplier into all 624 words, then returns to idle; in_stall stays high.
//   The state is twisted lazily: each draw rewrites the word it reads, so a
//   round of 624 draws gives exactly the whole-store twist.
//   Reset: no clearing pass. A flag marks that no seed has been taken yet;
//   until then the store counts as all zeros and every draw returns zero.
//   Output stall: the output register holds its word; one more draw may be
//   taken and waits in the compute state until the register frees up.
// ============================================================================
module mersenne_twister_generator
    import mtg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [WORD_W-1:0] seed_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] random_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [WORD_W-1:0] cur_reg;
    logic              seeded_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] word_reg;

    logic              accept;
    logic              draw_req;
    logic              seed_req;
    logic              finish;
    logic [ADDR_W-1:0] nxt_addr;
    logic [ADDR_W-1:0] far_addr;
    logic [WORD_W-1:0] nxt_data;
    logic [WORD_W-1:0] far_data;
    logic [WORD_W-1:0] new_word;
    mtg_wr_t           fill_wr;
    mtg_wr_t           ram_wr;
    logic              fill_busy;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign draw_req = accept && (action == ACT_DRAW);
    assign seed_req = accept && (action == ACT_RESEED);

    // neighbors of the current read position, modulo the store depth
    assign nxt_addr = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;
    assign far_addr = (pos_reg < WRAP_BASE) ? pos_reg + FAR_STEP : pos_reg - FAR_BACK;

    assign new_word = twist_word(cur_reg, nxt_data, far_data);

    // compute state finishes once the output register is free
    assign finish = (state_reg == ST_CALC) && (!out_valid_reg || !out_stall);

    // write back the twisted word, otherwise pass the fill writes
    always_comb
    begin
        ram_wr = fill_wr;
        if (finish && seeded_reg)
        begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = pos_reg;
            ram_wr.data = new_word;
        end
    end

    mtg_state_ram u_ram (
        .clk       (clk),
        .wr        (ram_wr),
        .rd_en     (draw_req),
        .rd_addr_a (nxt_addr),
        .rd_addr_b (far_addr),
        .rd_data_a (nxt_data),
        .rd_data_b (far_data)
    );

    mtg_seed_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_req),
        .seed  (seed_value),
        .wr    (fill_wr),
        .busy  (fill_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (draw_req)
                begin
                    state_next = ST_CALC;
                end
                else if (seed_req)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_CALC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (!fill_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_req)
            begin
                seeded_reg <= 1'b1;
                pos_reg    <= '0;
            end
            else if (finish)
            begin
                pos_reg <= nxt_addr;
            end
            // hold the result until taken; a finished draw reloads it
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_req)
        begin
            cur_reg <= seed_value;
        end
        else if (finish)
        begin
            // next word was read unmodified and becomes the current one
            cur_reg <= nxt_data;
        end
        if (finish)
        begin
            word_reg <= seeded_reg ? temper(new_word) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

    // ---------------------------------------------------------------- checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_ADDR)
        else $error("read position beyond the store");

    a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        fill_busy |-> in_stall)
        else $error("request taken during seed expansion");

    a_draw_calc: assert property (@(posedge clk) disable iff (!rst_n)
        draw_req |=> (state_reg == ST_CALC))
        else $error("draw not followed by compute");

    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !seeded_reg) |-> (word_reg == '0))
        else $error("nonzero word before any seed");

endmodule
